// ----- hw/rtl/bayer_bggr_bilinear_demosaic_assert.svh -----
// Assertion macros shared by the demosaic RTL modules.
`ifndef BAYER_BGGR_BILINEAR_DEMOSAIC_ASSERT_SVH
`define BAYER_BGGR_BILINEAR_DEMOSAIC_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define BBD_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bbd assertion failed");

// Check that cons holds in the cycle after ante.
`define BBD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bbd assertion failed");

`endif

// ----- hw/rtl/bbd_pkg.sv -----
// Shared constants and types of the BGGR bilinear demosaic.
`default_nettype none

package bbd_pkg;

   localparam int MAX_WIDTH   = 4096;
   localparam int MAX_HEIGHT  = 4096;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int ROW_W       = $clog2(MAX_HEIGHT);
   localparam int DIM_W       = 13;
   localparam int PIX_W       = 8;
   localparam int POS_W       = 12;
   localparam int CSR_IDX_W   = 2;
   localparam int QUEUE_DEPTH = 4;

   typedef logic [PIX_W-1:0] pix_type;

   // 3x3 window, [row][col]; row 0 is two lines up, col 0 two columns left
   typedef pix_type [2:0][2:0] win_type;

   // One line store entry: sample two lines up and one line up
   typedef struct packed {
      pix_type older;
      pix_type prior;
   } line_word_type;

   typedef struct packed {
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
      logic             mirror;
   } cfg_type;

   // Position of the newest sample of a window and its edge flags
   typedef struct packed {
      logic [COL_W-1:0] x;
      logic [ROW_W-1:0] y;
      logic             x_nz;
      logic             x_one;
      logic             x_last;
      logic             y_nz;
      logic             y_one;
      logic             y_last;
   } pos_type;

   typedef struct packed {
      win_type win;
      pos_type pos;
   } job_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH    = 2'd0,
      CSR_FRAME_HEIGHT   = 2'd1,
      CSR_MIRROR_COLUMNS = 2'd2
   } csr_index_type;

endpackage

`default_nettype wire

// ----- hw/rtl/bbd_front.sv -----
// Front end: request intake, position counters, line stores and 3x3 window.
`default_nettype none
`include "bayer_bggr_bilinear_demosaic_assert.svh"

module bbd_front
   import bbd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    req_valid,
   output logic    req_stall,
   input  pix_type req_raw_pixel,
   input  logic    req_frame_start,
   output logic    push_valid,
   input  logic    push_ready,
   output job_type push_job
);

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] cur_x;
   logic [ROW_W-1:0] cur_y;
   logic [DIM_W-1:0] x_inc, y_inc;
   pos_type          cur_pos;
   logic             accept, s1_advance;

   logic             s1_valid_ff, s1_valid_in;
   pix_type          s1_px_ff;
   pos_type          s1_pos_ff;
   logic             fwd_hit_ff, fwd_hit_in;
   line_word_type    fwd_word_ff;
   line_word_type    rd_word_ff;
   line_word_type    eff_word, new_word;
   win_type          win_ff, win_in;

   line_word_type    line_mem [MAX_WIDTH];

   // Handshake: stage one holds until the queue takes its job
   assign s1_advance = s1_valid_ff && push_ready;
   assign req_stall  = s1_valid_ff && !push_ready;
   assign accept     = req_valid && !req_stall;

   // Position of this request; restart at frame start or past the frame size
   always_comb begin
      cur_x = (req_frame_start || (DIM_W'(col_ff) >= cfg.width)) ? '0 : col_ff;
      cur_y = (req_frame_start || (DIM_W'(row_ff) >= cfg.height)) ? '0 : row_ff;
      x_inc = DIM_W'(cur_x) + 1'b1;
      y_inc = DIM_W'(cur_y) + 1'b1;
      if (x_inc >= cfg.width) begin
         col_in = '0;
         row_in = (y_inc >= cfg.height) ? '0 : y_inc[ROW_W-1:0];
      end else begin
         col_in = x_inc[COL_W-1:0];
         row_in = cur_y;
      end
      cur_pos.x      = cur_x;
      cur_pos.y      = cur_y;
      cur_pos.x_nz   = (cur_x != '0);
      cur_pos.x_one  = (cur_x == COL_W'(1));
      cur_pos.x_last = (DIM_W'(cur_x) == (cfg.width - 1'b1));
      cur_pos.y_nz   = (cur_y != '0);
      cur_pos.y_one  = (cur_y == ROW_W'(1));
      cur_pos.y_last = (DIM_W'(cur_y) == (cfg.height - 1'b1));
   end

   // Line store data, with the write of the previous request forwarded
   always_comb begin
      eff_word       = fwd_hit_ff ? fwd_word_ff : rd_word_ff;
      new_word.older = eff_word.prior;
      new_word.prior = s1_px_ff;
   end

   // Shift the window one column and load the new column
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 2; c++) begin
            win_in[r][c] = win_ff[r][c+1];
         end
      end
      win_in[0][2] = eff_word.older;
      win_in[1][2] = eff_word.prior;
      win_in[2][2] = s1_px_ff;
   end

   always_comb begin
      s1_valid_in = accept ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_ff);
      fwd_hit_in  = s1_advance && (s1_pos_ff.x == cur_x);
   end

   assign push_valid   = s1_valid_ff;
   assign push_job.win = win_in;
   assign push_job.pos = s1_pos_ff;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         fwd_hit_ff  <= 1'b0;
         win_ff      <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (accept) begin
            col_ff     <= col_in;
            row_ff     <= row_in;
            fwd_hit_ff <= fwd_hit_in;
         end
         if (s1_advance) begin
            win_ff <= win_in;
         end
      end
   end

   // Stage one payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_px_ff    <= req_raw_pixel;
         s1_pos_ff   <= cur_pos;
         fwd_word_ff <= new_word;
      end
   end

   // Line stores: read at intake, write back when the job leaves stage one
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_word_ff <= line_mem[cur_x];
      end
      if (s1_advance) begin
         line_mem[s1_pos_ff.x] <= new_word;
      end
   end

   `BBD_ASSERT_NEXT(a_accept_fills_stage, accept, s1_valid_ff)
   `BBD_ASSERT_NEXT(a_stage_holds, s1_valid_ff && !push_ready,
                    s1_valid_ff && $stable(s1_pos_ff) && $stable(s1_px_ff))
   `BBD_ASSERT_NEXT(a_window_holds, !s1_advance, $stable(win_ff))

endmodule

`default_nettype wire

// ----- hw/rtl/bbd_queue.sv -----
// Short job queue between the front end and the interpolation back end.
`default_nettype none
`include "bayer_bggr_bilinear_demosaic_assert.svh"

module bbd_queue
   import bbd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  job_type push_job,
   output logic    head_valid,
   output job_type head_job,
   input  logic    pop
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign push       = push_valid && push_ready;
   assign head_valid = (count_ff != '0);
   assign head_job   = slot_ff[rd_ptr_ff];

   // Advance pointers with wrap, track the fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed job
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   `BBD_ASSERT_NOW(a_pop_has_job, pop, count_ff != '0)
   `BBD_ASSERT_NEXT(a_count_up, push && !pop, count_ff == $past(count_ff) + 1'b1)
   `BBD_ASSERT_NEXT(a_count_down, pop && !push, count_ff == $past(count_ff) - 1'b1)

endmodule

`default_nettype wire

// ----- hw/rtl/bbd_back.sv -----
// Back end: walks the results of each job, interpolates RGB, drives the result port.
`default_nettype none
`include "bayer_bggr_bilinear_demosaic_assert.svh"

module bbd_back
   import bbd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  logic             head_valid,
   input  job_type          head_job,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pix_type          rsp_red,
   output pix_type          rsp_green,
   output pix_type          rsp_blue,
   output logic [POS_W-1:0] rsp_out_col,
   output logic [POS_W-1:0] rsp_out_line,
   output logic             rsp_last_of_run
);

   logic [3:0]       avail, pend, pick, rest;
   logic [3:0]       done_ff, done_in;
   logic [1:0]       sel;
   logic             out_free, emit_go;

   win_type          win;
   pos_type          pos;
   logic [1:0]       cc, lc, cr, ur;
   pix_type          ctr, lft, rgt, upv, dnv, ulv, urv, dlv, drv;
   logic [PIX_W+1:0] cross_sum, diag_sum;
   logic [PIX_W:0]   horz_sum, vert_sum;
   pix_type          cross_avg, diag_avg, horz_avg, vert_avg;
   logic [COL_W-1:0] cx;
   logic [ROW_W-1:0] cy;
   logic [DIM_W-1:0] mirror_col;
   pix_type          red_in, green_in, blue_in;
   logic [POS_W-1:0] col_in, line_in;

   logic             rsp_valid_ff;
   pix_type          red_ff, green_ff, blue_ff;
   logic [POS_W-1:0] col_ff, line_ff;
   logic             last_ff;

   assign win = head_job.win;
   assign pos = head_job.pos;

   // Results of a job in raster order: bit 0 picks column x, bit 1 picks row y
   always_comb begin
      avail[0] = pos.y_nz   && pos.x_nz;
      avail[1] = pos.y_nz   && pos.x_last;
      avail[2] = pos.y_last && pos.x_nz;
      avail[3] = pos.y_last && pos.x_last;
      pend     = avail & ~done_ff;
      sel      = 2'd0;
      for (int i = 3; i >= 0; i--) begin
         if (pend[i]) begin
            sel = 2'(i);
         end
      end
      pick = 4'b0001 << sel;
      rest = pend & ~pick;
   end

   // Emit when the output register frees; drop jobs without results
   always_comb begin
      out_free = !rsp_valid_ff || !rsp_stall;
      emit_go  = head_valid && (pend != '0) && out_free;
      pop      = head_valid && ((pend == '0) || (emit_go && (rest == '0)));
      if (pop) begin
         done_in = '0;
      end else if (emit_go) begin
         done_in = done_ff | pick;
      end else begin
         done_in = done_ff;
      end
   end

   // Clamped neighbor indexes inside the window; right and down never pass column/row 2
   always_comb begin
      cc = sel[0] ? 2'd2 : 2'd1;
      lc = sel[0] ? (pos.x_nz ? 2'd1 : 2'd2) : (pos.x_one ? 2'd1 : 2'd0);
      cr = sel[1] ? 2'd2 : 2'd1;
      ur = sel[1] ? (pos.y_nz ? 2'd1 : 2'd2) : (pos.y_one ? 2'd1 : 2'd0);
      ctr = win[cr][cc];
      lft = win[cr][lc];
      rgt = win[cr][2];
      upv = win[ur][cc];
      dnv = win[2][cc];
      ulv = win[ur][lc];
      urv = win[ur][2];
      dlv = win[2][lc];
      drv = win[2][2];
   end

   // Rounded averages
   always_comb begin
      cross_sum = (PIX_W+2)'(lft) + (PIX_W+2)'(rgt) + (PIX_W+2)'(upv)
                + (PIX_W+2)'(dnv) + (PIX_W+2)'(2);
      diag_sum  = (PIX_W+2)'(ulv) + (PIX_W+2)'(urv) + (PIX_W+2)'(dlv)
                + (PIX_W+2)'(drv) + (PIX_W+2)'(2);
      horz_sum  = (PIX_W+1)'(lft) + (PIX_W+1)'(rgt) + (PIX_W+1)'(1);
      vert_sum  = (PIX_W+1)'(upv) + (PIX_W+1)'(dnv) + (PIX_W+1)'(1);
      cross_avg = cross_sum[PIX_W+1:2];
      diag_avg  = diag_sum[PIX_W+1:2];
      horz_avg  = horz_sum[PIX_W:1];
      vert_avg  = vert_sum[PIX_W:1];
   end

   // Pixel position and color by BGGR site
   always_comb begin
      cx = sel[0] ? pos.x : pos.x - 1'b1;
      cy = sel[1] ? pos.y : pos.y - 1'b1;
      case ({cy[0], cx[0]})
         2'b00: begin
            blue_in  = ctr;
            green_in = cross_avg;
            red_in   = diag_avg;
         end
         2'b01: begin
            green_in = ctr;
            blue_in  = horz_avg;
            red_in   = vert_avg;
         end
         2'b10: begin
            green_in = ctr;
            red_in   = horz_avg;
            blue_in  = vert_avg;
         end
         2'b11: begin
            red_in   = ctr;
            green_in = cross_avg;
            blue_in  = diag_avg;
         end
      endcase
      mirror_col = cfg.width - 1'b1 - DIM_W'(cx);
      col_in     = cfg.mirror ? mirror_col[POS_W-1:0] : POS_W'(cx);
      line_in    = POS_W'(cy);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
         if (out_free) begin
            rsp_valid_ff <= emit_go;
         end
      end
   end

   // Output register payload
   always_ff @(posedge clock) begin
      if (emit_go) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
         col_ff   <= col_in;
         line_ff  <= line_in;
         last_ff  <= (rest == '0);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_red         = red_ff;
   assign rsp_green       = green_ff;
   assign rsp_blue        = blue_ff;
   assign rsp_out_col     = col_ff;
   assign rsp_out_line    = line_ff;
   assign rsp_last_of_run = last_ff;

   `BBD_ASSERT_NEXT(a_job_kept, emit_go && (rest != '0), head_valid)
   `BBD_ASSERT_NEXT(a_done_cleared, pop, done_ff == '0)
   `BBD_ASSERT_NEXT(a_result_shown, emit_go, rsp_valid_ff)

endmodule

`default_nettype wire

// ----- hw/rtl/bayer_bggr_bilinear_demosaic.sv -----
// Top level of the BGGR bilinear demosaic: configuration registers and block wiring.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   raw_pixel, frame_start
//   rsp      out        rsp_valid/rsp_stall   red, green, blue, out_col, out_line, last_of_run
//   csr      in         csr_valid/csr_ready   csr_index, csr_wdata
//
// One request per cycle while req_stall is low; result port moves one result per cycle while rsp_stall is low.
// A request at a row end or in the last row gives up to 4 results, so there the
// result port sets the rate, and req_stall rises once the 4-entry job queue fills.
// A request passes the stage-one register, a queue slot and the output register before its result appears.
// Reset clears counters, window, queue and output; size registers go to 4096,
// mirroring off. Line stores are not cleared; no warm-up after reset.
`default_nettype none

module bayer_bggr_bilinear_demosaic
   import bbd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [PIX_W-1:0]     req_raw_pixel,
   input  logic                 req_frame_start,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [PIX_W-1:0]     rsp_red,
   output logic [PIX_W-1:0]     rsp_green,
   output logic [PIX_W-1:0]     rsp_blue,
   output logic [POS_W-1:0]     rsp_out_col,
   output logic [POS_W-1:0]     rsp_out_line,
   output logic                 rsp_last_of_run,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_wdata
);

   localparam logic [DIM_W-1:0] MAX_W_DIM = DIM_W'(MAX_WIDTH);
   localparam logic [DIM_W-1:0] MAX_H_DIM = DIM_W'(MAX_HEIGHT);

   logic [DIM_W-1:0] width_ff, width_in;
   logic [DIM_W-1:0] height_ff, height_in;
   logic             mirror_ff;
   cfg_type          cfg;

   logic             push_valid, push_ready, head_valid, pop;
   job_type          push_job, head_job;

   assign csr_ready = 1'b1;

   // Clamp sizes into 1..max on write
   always_comb begin
      if (csr_wdata == '0) begin
         width_in  = DIM_W'(1);
         height_in = DIM_W'(1);
      end else begin
         width_in  = (csr_wdata > MAX_W_DIM) ? MAX_W_DIM : csr_wdata;
         height_in = (csr_wdata > MAX_H_DIM) ? MAX_H_DIM : csr_wdata;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= MAX_W_DIM;
         height_ff <= MAX_H_DIM;
         mirror_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:    width_ff  <= width_in;
            CSR_FRAME_HEIGHT:   height_ff <= height_in;
            CSR_MIRROR_COLUMNS: mirror_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign cfg.width  = width_ff;
   assign cfg.height = height_ff;
   assign cfg.mirror = mirror_ff;

   bbd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_raw_pixel   (req_raw_pixel),
      .req_frame_start (req_frame_start),
      .push_valid      (push_valid),
      .push_ready      (push_ready),
      .push_job        (push_job)
   );

   bbd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop)
   );

   bbd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .head_valid      (head_valid),
      .head_job        (head_job),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .rsp_out_col     (rsp_out_col),
      .rsp_out_line    (rsp_out_line),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

`default_nettype wire
